/* rtl/srt_pkg.sv */
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants of the sorted record table
// Holds the record layout, operation and status codes, the controller state
// encoding and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package srt_pkg;

	localparam int SRT_DEPTH   = 16;
	localparam int ID_W        = 32;
	localparam int CODE_W      = 32;
	localparam int CLS_W       = 8;
	localparam int FILL_W      = 5;
	localparam int STAT_W      = 2;
	localparam int KIND_W      = 3;
	localparam int S_TDATA_W   = 72;
	localparam int M_TDATA_W   = 80;
	localparam int M_PAD_W     = M_TDATA_W - (ID_W + CODE_W + CLS_W + FILL_W);

	typedef enum logic [KIND_W-1:0] {
		KIND_SEARCH   = 3'd0,
		KIND_APPEND   = 3'd1,
		KIND_INSERT   = 3'd2,
		KIND_DELETE   = 3'd3,
		KIND_FILTER   = 3'd4,
		KIND_TRANSFER = 3'd5
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_NO_MATCH  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [CLS_W-1:0]  cls;
		logic [CODE_W-1:0] code;
		logic [ID_W-1:0]   id;
	} record_t;

	// controller -> datapath
	typedef struct packed {
		logic load;        // latch the accepted word, clear the walk
		logic rd;          // issue a table read at the walk index
		logic ev;          // consume the read entry, advance the walk
		logic fin;         // commit the table update and post the status word
		logic pass2_start; // rewind the walk for the emit pass
		logic pass2_end;   // close the emit pass
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_kind_ok;  // incoming kind is a defined operation
		logic done;        // walk is over for this pass
		logic filt;        // operation is filter or transfer
		logic pass2;       // emit pass running
		logic n_zero;      // no class match found in the count pass
		logic need_emit;   // current entry produces a record word
		logic obuf_free;   // output register can take a word this cycle
	} stat_t;

endpackage

/* rtl/srt_ram.sv */
// ----------------------------------------------------------------------------
// srt_ram: generic single-write, single-read memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module srt_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/srt_ctrl.sv */
// ----------------------------------------------------------------------------
// srt_ctrl: operation sequencer of the sorted record table
// Walks the table one entry per read/evaluate pair and hands commands to the
// datapath.
// ----------------------------------------------------------------------------
module srt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  srt_pkg::stat_t stat,
	output srt_pkg::cmd_t  cmd
);

	import srt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.load = 1'b1;
					// drop undefined kinds without a result
					if (stat.in_kind_ok) begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				if (stat.done) begin
					if (stat.pass2) begin
						cmd.pass2_end = 1'b1;
						state_d       = S_IDLE;
					end else if (stat.filt && !stat.n_zero) begin
						cmd.pass2_start = 1'b1;
					end else begin
						state_d = S_FINISH;
					end
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				// hold the entry while a record word waits for room
				if (!stat.need_emit || stat.obuf_free) begin
					cmd.ev  = 1'b1;
					state_d = S_READ;
				end
			end
			S_FINISH: begin
				if (stat.obuf_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_eval_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL) |-> ($past(state_q) == S_READ || $past(state_q) == S_EVAL))
		else $error("evaluate state entered without a read");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.rd, cmd.ev, cmd.fin, cmd.pass2_start, cmd.pass2_end}))
		else $error("more than one datapath command at once");
`endif

endmodule

/* rtl/srt_dpath.sv */
// ----------------------------------------------------------------------------
// srt_dpath: storage and evaluation datapath of the sorted record table
// Record memory, fill count, walk counters, carry register and output word.
// ----------------------------------------------------------------------------
module srt_dpath #(
	parameter int DEPTH = srt_pkg::SRT_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  srt_pkg::cmd_t                  cmd,
	output srt_pkg::stat_t                 stat,
	input  logic [srt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	input  logic [srt_pkg::KIND_W-1:0]     s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [srt_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	output logic [srt_pkg::STAT_W-1:0]     m_axis_tuser,
	output logic                           m_axis_tlast
);

	import srt_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int RW = $bits(record_t);

	// item registers
	logic [KIND_W-1:0] kind_q;
	logic [ID_W-1:0]   key_q;
	logic [CODE_W-1:0] code_q;
	logic [CLS_W-1:0]  cls_q;

	// walk state
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] wp_q;
	logic          found_q;
	logic          placed_q;
	logic          pass2_q;
	record_t       carry_q;

	// output word
	logic              oval_q;
	logic [STAT_W-1:0] ostat_q;
	record_t           orec_q;
	logic [FILL_W-1:0] ofill_q;
	logic              olast_q;

	record_t       rd_rec;
	record_t       new_rec;
	logic          we;
	logic [IW-1:0] waddr;
	record_t       wdata;
	logic          is_search, is_append, is_insert, is_delete, is_filter, is_transfer;
	logic          full, at_end, id_hit, cls_hit, id_less;
	logic [CW-1:0] idx_m1;
	logic [CW-1:0] fin_count;
	status_t       fin_stat;
	logic [CW-1:0] emit_count;
	logic          load_out;

	assign is_search   = (kind_q == KIND_SEARCH);
	assign is_append   = (kind_q == KIND_APPEND);
	assign is_insert   = (kind_q == KIND_INSERT);
	assign is_delete   = (kind_q == KIND_DELETE);
	assign is_filter   = (kind_q == KIND_FILTER);
	assign is_transfer = (kind_q == KIND_TRANSFER);

	assign new_rec = '{cls: cls_q, code: code_q, id: key_q};
	assign full    = (count_q == CW'(DEPTH));
	assign at_end  = (idx_q == count_q);
	assign id_hit  = (rd_rec.id == key_q);
	assign cls_hit = (rd_rec.cls == cls_q);
	assign id_less = ($signed(rd_rec.id) < $signed(key_q));
	assign idx_m1  = idx_q - CW'(1);

	assign stat.in_kind_ok = (s_axis_tuser <= KIND_TRANSFER);
	assign stat.done       = at_end || is_append || (is_insert && full) ||
	                         (is_search && found_q);
	assign stat.filt       = is_filter || is_transfer;
	assign stat.pass2      = pass2_q;
	assign stat.n_zero     = (n_q == '0);
	assign stat.need_emit  = pass2_q && cls_hit;
	assign stat.obuf_free  = !oval_q || m_axis_tready;

	srt_ram #(
		.WIDTH (RW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (idx_q[IW-1:0]),
		.rdata (rd_rec)
	);

	// table write port: shifts and the new record during the walk, the tail write at the finish
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[IW-1:0];
		wdata = rd_rec;
		if (cmd.ev) begin
			if (is_delete && found_q) begin
				we    = 1'b1;
				waddr = idx_m1[IW-1:0];
			end else if (is_insert && placed_q) begin
				we    = 1'b1;
				wdata = carry_q;
			end else if (is_insert && !id_less) begin
				we    = 1'b1;
				wdata = new_rec;
			end else if (is_transfer && pass2_q && !cls_hit) begin
				we    = 1'b1;
				waddr = wp_q[IW-1:0];
			end
		end else if (cmd.fin && (is_append || is_insert) && !full) begin
			we    = 1'b1;
			waddr = count_q[IW-1:0];
			wdata = placed_q ? carry_q : new_rec;
		end
	end

	// final status word
	always_comb begin
		fin_count = count_q;
		fin_stat  = ST_OK;
		case (kind_q)
			KIND_SEARCH: begin
				fin_stat = found_q ? ST_OK : ST_NOT_FOUND;
			end
			KIND_APPEND, KIND_INSERT: begin
				if (full) begin
					fin_stat = ST_FULL;
				end else begin
					fin_count = count_q + CW'(1);
				end
			end
			KIND_DELETE: begin
				if (found_q) begin
					fin_count = count_q - CW'(1);
				end else begin
					fin_stat = ST_NOT_FOUND;
				end
			end
			default: begin
				fin_stat = ST_NO_MATCH;
			end
		endcase
	end

	assign emit_count = is_transfer ? (count_q - n_q) : count_q;
	assign load_out   = cmd.fin || (cmd.ev && pass2_q && cls_hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			idx_q    <= '0;
			n_q      <= '0;
			k_q      <= '0;
			wp_q     <= '0;
			found_q  <= 1'b0;
			placed_q <= 1'b0;
			pass2_q  <= 1'b0;
			oval_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q    <= '0;
				n_q      <= '0;
				k_q      <= '0;
				wp_q     <= '0;
				found_q  <= 1'b0;
				placed_q <= 1'b0;
				pass2_q  <= 1'b0;
			end
			if (cmd.pass2_start) begin
				idx_q   <= '0;
				pass2_q <= 1'b1;
			end
			if (cmd.pass2_end) begin
				pass2_q <= 1'b0;
				if (is_transfer) begin
					count_q <= count_q - n_q;
				end
			end
			if (cmd.ev) begin
				idx_q <= idx_q + CW'(1);
				if ((is_search || is_delete) && !found_q && id_hit) begin
					found_q <= 1'b1;
				end
				if (is_insert && !placed_q && !id_less) begin
					placed_q <= 1'b1;
				end
				if ((is_filter || is_transfer) && !pass2_q && cls_hit) begin
					n_q <= n_q + CW'(1);
				end
				if (pass2_q && cls_hit) begin
					k_q <= k_q + CW'(1);
				end
				if (pass2_q && !cls_hit) begin
					wp_q <= wp_q + CW'(1);
				end
			end
			if (cmd.fin) begin
				count_q <= fin_count;
			end
			if (load_out) begin
				oval_q <= 1'b1;
			end else if (m_axis_tready) begin
				oval_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= s_axis_tuser;
			key_q  <= s_axis_tdata[ID_W-1:0];
			code_q <= s_axis_tdata[ID_W +: CODE_W];
			cls_q  <= s_axis_tdata[ID_W + CODE_W +: CLS_W];
		end
		if (cmd.ev && is_insert && (placed_q || !id_less)) begin
			carry_q <= rd_rec;
		end
		if (cmd.fin) begin
			ostat_q <= fin_stat;
			orec_q  <= '0;
			ofill_q <= FILL_W'(fin_count);
			olast_q <= 1'b1;
		end else if (load_out) begin
			ostat_q <= ST_OK;
			orec_q  <= rd_rec;
			ofill_q <= FILL_W'(emit_count);
			olast_q <= ((k_q + CW'(1)) == n_q);
		end
	end

	assign m_axis_tvalid = oval_q;
	assign m_axis_tdata  = {{M_PAD_W{1'b0}}, ofill_q, orec_q.cls, orec_q.code, orec_q.id};
	assign m_axis_tuser  = ostat_q;
	assign m_axis_tlast  = olast_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= CW'(DEPTH)) && (idx_q <= CW'(DEPTH)))
		else $error("fill count or walk index out of range");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!oval_q || m_axis_tready))
		else $error("output word overwritten while stalled");
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pass2_q |-> (k_q <= n_q))
		else $error("more records emitted than counted");
`endif

endmodule

/* rtl/sorted_record_table_unit.sv */
// ----------------------------------------------------------------------------
// sorted_record_table_unit: ordered record table with search and edit ops
// Keeps up to DEPTH records (id, code, class) in order with a fill count and
// runs one search, append, sorted insert, delete, filter or transfer per word.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                        | tuser   | tlast
//  ---------+-----+-------------------------------------------+---------+-------
//  s_axis   | in  | key_id[31:0] item_code[31:0] class_byte   | kind    | -
//  m_axis   | out | rec_id rec_code rec_class fill_count, pad | status  | last
//
//  Flow: one word is taken in the idle state; every table entry passes
//  through a read state and an evaluate state on the record memory.
//  Search, insert and delete walk the table once (search stops at the
//  first hit, insert stops at once on a full table, append does not walk);
//  filter and transfer walk the table twice, once to count matches and once
//  to emit, or only once when nothing matches.
//  Reset clears the fill count and the control state; record memory is not
//  cleared, since only entries below the count are ever read.
//  A stalled m_axis holds the walk at the entry that waits to be sent; a new
//  word is taken while the previous final result still sits in the output
//  register.
//
module sorted_record_table_unit #(
	parameter int DEPTH = srt_pkg::SRT_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// key_id[31:0], item_code[63:32], class_byte[71:64]
	input  logic [srt_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// kind[2:0]
	input  logic [srt_pkg::KIND_W-1:0]    s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// rec_id[31:0], rec_code[63:32], rec_class[71:64], fill_count[76:72], zeros
	output logic [srt_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// status[1:0]
	output logic [srt_pkg::STAT_W-1:0]    m_axis_tuser,
	output logic                          m_axis_tlast
);

	import srt_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer: accepts words and steps the walk
	srt_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	// datapath: record memory, counters and the output register
	srt_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

`ifndef NO_ASSERTIONS
	a_ready_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready || !stat.in_kind_ok ||
		$past(!stat.in_kind_ok))
		else $error("second word accepted while an operation runs");
`endif

endmodule

/* test/sorted_record_table_unit_test.sv */
// ----------------------------------------------------------------------------
// sorted_record_table_unit_test: self-checking bench for the record table
// Streams search, append, sorted insert, delete, filter and transfer words
// into the table, predicts every result word from a behavioral copy of the
// table and checks each field of each word, with random idling on both sides.
// ----------------------------------------------------------------------------
module sorted_record_table_unit_test;

	timeunit 1ns;
	timeprecision 1ps;

	import srt_pkg::*;

	// kinds with no operation behind them; the block must swallow them
	localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

	// m_axis tdata layout, lowest field first
	localparam int OUT_CODE_LO = ID_W;
	localparam int OUT_CLS_LO  = ID_W + CODE_W;
	localparam int OUT_FILL_LO = ID_W + CODE_W + CLS_W;
	localparam int OUT_PAD_LO  = OUT_FILL_LO + FILL_W;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 120;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   key;
		logic [CODE_W-1:0] code;
		logic [CLS_W-1:0]  cls;
	} op_word_t;

	typedef struct {
		status_t           status;
		logic [ID_W-1:0]   id;
		logic [CODE_W-1:0] code;
		logic [CLS_W-1:0]  cls;
		logic [FILL_W-1:0] fill;
		logic              last;
	} table_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [KIND_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [STAT_W-1:0] m_axis_tuser;
	logic m_axis_tlast;

	sorted_record_table_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// words waiting to be sent, and result words the table owes us
	op_word_t    pending_ops[$];
	table_word_t expected_words[$];

	// behavioral copy of the table
	logic [ID_W-1:0]   tbl_id[SRT_DEPTH];
	logic [CODE_W-1:0] tbl_code[SRT_DEPTH];
	logic [CLS_W-1:0]  tbl_cls[SRT_DEPTH];
	int                tbl_fill = 0;

	int error_count = 0;
	int results_checked = 0;
	int words_taken = 0;
	int full_seen = 0;
	int no_match_seen = 0;
	int cycle_count = 0;

	logic word_taken = 1'b0;  // input word went in at the last rising edge
	logic calm = 1'b0;        // closing stretch: no idling on either side
	logic bursty = 1'b1;      // idling bursts allowed in the current stretch
	int   send_gap = 0;
	int   sink_stall = 0;

	// id pool keeps searches, deletes and duplicates frequent
	logic [ID_W-1:0] id_pool[8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
		32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0010, 32'hFFFF_FFF0, 32'h0000_0003};

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		error_count++;
		$display("mismatch on %s at result %0d: got %h, expected %h",
			field, results_checked, got, want);
	endtask

	task automatic queue_op(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] key,
		input logic [CODE_W-1:0] code, input logic [CLS_W-1:0] cls);
		op_word_t w;
		w.kind = kind;
		w.key  = key;
		w.code = code;
		w.cls  = cls;
		pending_ops.push_back(w);
	endtask

	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return id_pool[$urandom_range(0, 7)];
	endfunction

	function automatic logic [CLS_W-1:0] pick_class();
		if ($urandom_range(0, 3) == 0)
			return CLS_W'($urandom_range(0, 255));
		return CLS_W'($urandom_range(0, 3));
	endfunction

	// append one owed result word; fill is the count after the whole operation
	task automatic owe_word(input status_t st, input logic [ID_W-1:0] id,
		input logic [CODE_W-1:0] code, input logic [CLS_W-1:0] cls, input logic last);
		table_word_t w;
		w.status = st;
		w.id     = id;
		w.code   = code;
		w.cls    = cls;
		w.fill   = tbl_fill[FILL_W-1:0];
		w.last   = last;
		expected_words.push_back(w);
		if (st == ST_FULL)
			full_seen++;
		if (st == ST_NO_MATCH)
			no_match_seen++;
	endtask

	function automatic int locate_id(input logic [ID_W-1:0] key);
		int x;
		x = 0;
		while (x < tbl_fill && tbl_id[x] != key)
			x++;
		return x;
	endfunction

	// close the gap at position x
	task automatic close_gap(input int x);
		int y;
		for (y = x; y + 1 < tbl_fill; y++) begin
			tbl_id[y]   = tbl_id[y + 1];
			tbl_code[y] = tbl_code[y + 1];
			tbl_cls[y]  = tbl_cls[y + 1];
		end
		tbl_fill--;
	endtask

	// run one operation on the table copy and queue the words it causes
	task automatic apply_table_op(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] key,
		input logic [CODE_W-1:0] code, input logic [CLS_W-1:0] cls);
		int x;
		int y;
		int n;
		logic [ID_W-1:0]   hit_id[SRT_DEPTH];
		logic [CODE_W-1:0] hit_code[SRT_DEPTH];
		logic [CLS_W-1:0]  hit_cls[SRT_DEPTH];
		case (kind)
			KIND_SEARCH: begin
				owe_word(locate_id(key) < tbl_fill ? ST_OK : ST_NOT_FOUND, '0, '0, '0, 1'b1);
			end
			KIND_APPEND, KIND_INSERT: begin
				if (tbl_fill >= SRT_DEPTH) begin
					owe_word(ST_FULL, '0, '0, '0, 1'b1);
				end else begin
					x = tbl_fill;
					if (kind == KIND_INSERT) begin
						// stop at the first id that is not smaller, signed
						x = 0;
						while (x < tbl_fill && $signed(tbl_id[x]) < $signed(key))
							x++;
						for (y = tbl_fill; y > x; y--) begin
							tbl_id[y]   = tbl_id[y - 1];
							tbl_code[y] = tbl_code[y - 1];
							tbl_cls[y]  = tbl_cls[y - 1];
						end
					end
					tbl_id[x]   = key;
					tbl_code[x] = code;
					tbl_cls[x]  = cls;
					tbl_fill++;
					owe_word(ST_OK, '0, '0, '0, 1'b1);
				end
			end
			KIND_DELETE: begin
				x = locate_id(key);
				if (x < tbl_fill) begin
					close_gap(x);
					owe_word(ST_OK, '0, '0, '0, 1'b1);
				end else begin
					owe_word(ST_NOT_FOUND, '0, '0, '0, 1'b1);
				end
			end
			KIND_FILTER, KIND_TRANSFER: begin
				n = 0;
				x = 0;
				while (x < tbl_fill) begin
					if (tbl_cls[x] == cls) begin
						hit_id[n]   = tbl_id[x];
						hit_code[n] = tbl_code[x];
						hit_cls[n]  = tbl_cls[x];
						n++;
						if (kind == KIND_TRANSFER)
							close_gap(x);
						else
							x++;
					end else begin
						x++;
					end
				end
				if (n == 0) begin
					owe_word(ST_NO_MATCH, '0, '0, '0, 1'b1);
				end else begin
					for (y = 0; y < n; y++)
						owe_word(ST_OK, hit_id[y], hit_code[y], hit_cls[y], y + 1 == n);
				end
			end
			default: begin
				// spare kinds: no result, no change
			end
		endcase
	endtask

	// Source side: advance to the next pending word once the current one is
	// taken; insert idle bursts between words while idling is allowed.
	always @(negedge clk) begin
		op_word_t nxt;
		logic drive_valid;
		drive_valid = s_axis_tvalid;
		if (arst_n && (!s_axis_tvalid || word_taken)) begin
			drive_valid = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_ops.size() > 0) begin
				if (!calm && bursty && $urandom_range(0, 4) == 0) begin
					send_gap = $urandom_range(1, 19) - 1;
				end else begin
					nxt = pending_ops.pop_front();
					s_axis_tdata <= {nxt.cls, nxt.code, nxt.key};
					s_axis_tuser <= nxt.kind;
					drive_valid = 1'b1;
					if ($urandom_range(0, 11) == 0)
						bursty = !bursty;
				end
			end
		end
		s_axis_tvalid <= drive_valid;
		calm <= pending_ops.size() < 20;
	end

	// Sink side: drop tready in random bursts, hold it high in the closing stretch.
	always @(negedge clk) begin
		logic drive_ready;
		drive_ready = 1'b1;
		if (!arst_n) begin
			drive_ready = 1'b0;
		end else if (sink_stall > 0) begin
			sink_stall--;
			drive_ready = 1'b0;
		end else if (!calm && bursty && $urandom_range(0, 7) == 0) begin
			sink_stall = $urandom_range(1, 19) - 1;
			drive_ready = 1'b0;
		end
		m_axis_tready <= drive_ready;
	end

	// Monitor: predict on every accepted input word, check every accepted
	// result word against the oldest one owed.
	always @(posedge clk) begin
		table_word_t want;
		word_taken <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			words_taken++;
			apply_table_op(s_axis_tuser, s_axis_tdata[ID_W-1:0],
				s_axis_tdata[ID_W+CODE_W-1:ID_W], s_axis_tdata[S_TDATA_W-1:ID_W+CODE_W]);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", m_axis_tdata[ID_W-1:0], '0);
			end else begin
				want = expected_words.pop_front();
				if (m_axis_tuser !== want.status)
					report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
				if (m_axis_tdata[ID_W-1:0] !== want.id)
					report_mismatch("rec_id", m_axis_tdata[ID_W-1:0], want.id);
				if (m_axis_tdata[OUT_CLS_LO-1:OUT_CODE_LO] !== want.code)
					report_mismatch("rec_code", m_axis_tdata[OUT_CLS_LO-1:OUT_CODE_LO],
						want.code);
				if (m_axis_tdata[OUT_FILL_LO-1:OUT_CLS_LO] !== want.cls)
					report_mismatch("rec_class", 32'(m_axis_tdata[OUT_FILL_LO-1:OUT_CLS_LO]),
						32'(want.cls));
				if (m_axis_tdata[OUT_PAD_LO-1:OUT_FILL_LO] !== want.fill)
					report_mismatch("fill_count", 32'(m_axis_tdata[OUT_PAD_LO-1:OUT_FILL_LO]),
						32'(want.fill));
				if (m_axis_tdata[M_TDATA_W-1:OUT_PAD_LO] !== '0)
					report_mismatch("pad bits", 32'(m_axis_tdata[M_TDATA_W-1:OUT_PAD_LO]), '0);
				if (m_axis_tlast !== want.last)
					report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
				results_checked++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still owed",
				cycle_count, expected_words.size());
			$display("sorted_record_table_unit_test NOT OK");
			$finish;
		end
	end

	initial begin
		int round_no;
		int n;
		int r;
		int c;
		logic [KIND_W-1:0] k;

		// directed: empty table, spare kinds, id and field extremes, duplicates
		queue_op(KIND_SEARCH, 32'h0000_0000, 32'h0000_0000, 8'h00);
		queue_op(KIND_DELETE, 32'h0000_0000, 32'h0000_0000, 8'h00);
		queue_op(KIND_FILTER, 32'h0000_0000, 32'h0000_0000, 8'h00);
		queue_op(KIND_TRANSFER, 32'h0000_0000, 32'h0000_0000, 8'h00);
		queue_op(KIND_SPARE_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		queue_op(KIND_SPARE_B, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		queue_op(KIND_INSERT, 32'h0000_0000, 32'h0000_0000, 8'h00);
		queue_op(KIND_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		queue_op(KIND_INSERT, 32'h8000_0000, 32'h8000_0000, 8'hFF);
		queue_op(KIND_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 8'h01);
		queue_op(KIND_APPEND, 32'h7FFF_FFFF, 32'h1234_5678, 8'hFF);
		queue_op(KIND_INSERT, 32'h0000_0000, 32'h0000_0001, 8'h80);
		queue_op(KIND_SEARCH, 32'h8000_0000, 32'h0000_0000, 8'h00);
		queue_op(KIND_SEARCH, 32'h7FFF_FFFE, 32'h0000_0000, 8'h00);
		queue_op(KIND_FILTER, 32'h0000_0000, 32'h0000_0000, 8'hFF);
		queue_op(KIND_DELETE, 32'h7FFF_FFFF, 32'h0000_0000, 8'h00);
		queue_op(KIND_DELETE, 32'h0001_2345, 32'h0000_0000, 8'h00);
		queue_op(KIND_FILTER, 32'h0000_0000, 32'h0000_0000, 8'hAA);
		queue_op(KIND_TRANSFER, 32'h0000_0000, 32'h0000_0000, 8'hFF);
		queue_op(KIND_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000, 8'h00);
		queue_op(KIND_TRANSFER, 32'h0000_0000, 32'h0000_0000, 8'h00);
		queue_op(KIND_FILTER, 32'h0000_0000, 32'h0000_0000, 8'h80);

		// random rounds: fill runs that overflow the table, mixed edits,
		// class drains, and a little noise
		round_no = 0;
		n = 0;
		while (n < 78) begin
			r = (round_no == 0) ? 0 : $urandom_range(0, 4);
			case (r)
				0: begin
					c = (round_no == 0) ? 18 : $urandom_range(6, 18);
					repeat (c) begin
						k = $urandom_range(0, 1) ? KIND_INSERT : KIND_APPEND;
						queue_op(k, pick_id(), $urandom, pick_class());
						n++;
					end
				end
				1, 2: begin
					repeat (8) begin
						case ($urandom_range(0, 9))
							0, 1:    k = KIND_SEARCH;
							2, 3:    k = KIND_DELETE;
							4:       k = KIND_FILTER;
							5:       k = KIND_TRANSFER;
							6, 7:    k = KIND_INSERT;
							default: k = KIND_APPEND;
						endcase
						queue_op(k, pick_id(), $urandom, pick_class());
						n++;
					end
				end
				3: begin
					for (c = 0; c < 4; c++) begin
						k = $urandom_range(0, 1) ? KIND_TRANSFER : KIND_FILTER;
						queue_op(k, $urandom, $urandom, CLS_W'(c));
						n++;
					end
				end
				default: begin
					k = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
					queue_op(k, $urandom, $urandom, CLS_W'($urandom_range(0, 255)));
					queue_op(KIND_SEARCH, $urandom, $urandom, CLS_W'($urandom_range(0, 255)));
					n += 2;
				end
			endcase
			round_no++;
		end

		// hold reset, then release it on a falling edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait until every word is sent and every result has come back
		@(posedge clk);
		while (pending_ops.size() > 0 || s_axis_tvalid || expected_words.size() > 0)
			@(posedge clk);
		// give a late or spurious word time to show up
		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_words.size() != 0)
			report_mismatch("words never sent", '0, expected_words.size());

		$display("ran %0d operation words through the table, checked %0d result words",
			words_taken, results_checked);
		$display("among them %0d table-full and %0d no-match statuses, %0d errors",
			full_seen, no_match_seen, error_count);
		if (error_count == 0) begin
			$display("sorted_record_table_unit_test OK");
		end else begin
			$display("sorted_record_table_unit_test NOT OK");
		end
		$finish;
	end

endmodule
